@@ hw/rtl/tucs_pkg.sv @@
package tucs_pkg;

  localparam logic [7:0]  TCP_PROTO     = 8'd6;
  localparam logic [7:0]  UDP_PROTO     = 8'd17;
  localparam logic [4:0]  TCP_CSUM_POS  = 5'd16;
  localparam logic [4:0]  UDP_CSUM_POS  = 5'd6;
  localparam logic [4:0]  NO_CSUM_POS   = 5'd0;
  localparam logic [3:0]  VERSION_IPV4  = 4'h4;
  localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
  localparam logic [15:0] IDX_VER_IHL   = 16'd0;
  localparam logic [15:0] IDX_LEN_HI    = 16'd2;
  localparam logic [15:0] IDX_LEN_LO    = 16'd3;
  localparam logic [15:0] IDX_PROTO     = 16'd9;
  localparam logic [15:0] IDX_ADDR_LO   = 16'd12;
  localparam logic [15:0] IDX_ADDR_HI   = 16'd19;
  localparam logic [15:0] IDX_MAX       = 16'hFFFF;
  localparam logic [15:0] CSUM_ALL_ONES = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_VALID       = 3'd0,
    ST_NOT_IPV4    = 3'd1,
    ST_OTHER_PROTO = 3'd2,
    ST_SEG_SHORT   = 3'd3,
    ST_HDR_SHORT   = 3'd4,
    ST_TRUNCATED   = 3'd5
  } status_e;

  // packet state captured on the last beat
  typedef struct packed {
    logic [15:0] sum;
    logic [3:0]  hdr_words;
    logic        version_ok;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [15:0] count;
  } snap_t;

  typedef struct packed {
    logic [15:0] value;
    logic [15:0] offset;
    status_e     status;
  } result_t;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

  function automatic logic [4:0] csum_pos(input logic [7:0] proto);
    logic [4:0] p;
    if (proto == TCP_PROTO) begin
      p = TCP_CSUM_POS;
    end else if (proto == UDP_PROTO) begin
      p = UDP_CSUM_POS;
    end else begin
      p = NO_CSUM_POS;
    end
    return p;
  endfunction

endpackage

@@ hw/rtl/tucs_finish.sv @@
module tucs_finish (
  input  tucs_pkg::snap_t   snap_i,
  output tucs_pkg::result_t result_o
);
  import tucs_pkg::*;

  logic [6:0]  hdr;
  logic [4:0]  pos;
  logic [6:0]  csum_off;
  logic [7:0]  min_len;
  logic [15:0] seg_len;
  logic [15:0] s_proto;
  logic [15:0] s_all;
  logic [15:0] csum;

  assign hdr      = {1'b0, snap_i.hdr_words, 2'b00};
  assign pos      = csum_pos(snap_i.proto);
  assign csum_off = hdr + {2'b0, pos};
  assign min_len  = {1'b0, csum_off} + 8'd2;
  assign seg_len  = snap_i.total_len - {9'b0, hdr};
  assign s_proto  = ones_add(snap_i.sum, {8'b0, snap_i.proto});
  assign s_all    = ones_add(s_proto, seg_len);

  always_comb begin
    csum = ~s_all;
    // UDP reserves zero for "no checksum"
    if (snap_i.proto == UDP_PROTO && csum == 16'd0) begin
      csum = CSUM_ALL_ONES;
    end
  end

  always_comb begin
    result_o.value  = 16'd0;
    result_o.offset = 16'd0;
    if (!snap_i.version_ok) begin
      result_o.status = ST_NOT_IPV4;
    end else if (snap_i.hdr_words < MIN_HDR_WORDS) begin
      result_o.status = ST_HDR_SHORT;
    end else if (snap_i.count < {9'b0, hdr}) begin
      result_o.status = ST_TRUNCATED;
    end else if (pos == NO_CSUM_POS) begin
      result_o.status = ST_OTHER_PROTO;
    end else if (snap_i.total_len < {8'b0, min_len}) begin
      result_o.status = ST_SEG_SHORT;
    end else if (snap_i.count < snap_i.total_len) begin
      result_o.status = ST_TRUNCATED;
    end else begin
      result_o.status = ST_VALID;
      result_o.value  = csum;
      result_o.offset = {9'b0, csum_off};
    end
  end

endmodule

@@ hw/rtl/tcp_udp_checksum_stream_unit.sv @@
// Takes one packet byte per cycle, back to back, including across packet ends, unless the result output stalls.
// After the beat carrying tlast, the result is registered in the snapshot stage, then in the output stage.
// Throughput: 1 byte per cycle unless stalled; set by the single end-around-carry add per byte.
// Async active-low reset clears the packet state and the valid flags of both output stages, not their data.
// Packet state returns to its reset value after each last beat.
module tcp_udp_checksum_stream_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] checksum_value, [31:16] checksum_offset
  output logic [2:0]  m_axis_tuser    // [2:0] status
);
  import tucs_pkg::*;

  logic [15:0] idx_q, idx_d;
  logic [15:0] sum_q, sum_d;
  logic [3:0]  hw_q, hw_d;
  logic [15:0] tl_q, tl_d;
  logic [7:0]  proto_q, proto_d;
  logic        ver_q, ver_d;

  logic        fin_valid_q, fin_valid_d;
  snap_t       snap_q;
  snap_t       snap_new;
  logic        out_valid_q, out_valid_d;
  result_t     out_q;
  result_t     result;

  logic        in_beat;
  logic        advance;

  logic [3:0]  hw_n;
  logic        ver_n;
  logic [15:0] tl_n;
  logic [7:0]  proto_n;
  logic [5:0]  hdr;
  logic [4:0]  pos;
  logic [6:0]  csum_off;
  logic        csum_hit;
  logic        in_seg;
  logic        in_addr;
  logic [15:0] word;
  logic [15:0] sum_n;
  logic [15:0] idx_n;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !fin_valid_q || advance;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // header fields take effect on the byte that carries them
  always_comb begin
    hw_n    = hw_q;
    ver_n   = ver_q;
    tl_n    = tl_q;
    proto_n = proto_q;
    if (idx_q == IDX_VER_IHL) begin
      hw_n  = s_axis_tdata[3:0];
      ver_n = s_axis_tdata[7:4] == VERSION_IPV4;
    end else if (idx_q == IDX_LEN_HI) begin
      tl_n = {s_axis_tdata, tl_q[7:0]};
    end else if (idx_q == IDX_LEN_LO) begin
      tl_n = {tl_q[15:8], s_axis_tdata};
    end else if (idx_q == IDX_PROTO) begin
      proto_n = s_axis_tdata;
    end
  end

  assign hdr      = {hw_n, 2'b00};
  assign pos      = csum_pos(proto_n);
  assign csum_off = {1'b0, hdr} + {2'b0, pos};
  // csum_off is even, so both checksum bytes share idx[15:1]
  assign csum_hit = (pos != NO_CSUM_POS) && (idx_q[15:1] == {9'b0, csum_off[6:1]});
  assign in_seg   = (idx_q >= {10'b0, hdr}) && (idx_q < tl_n) && !csum_hit;
  assign in_addr  = (idx_q >= IDX_ADDR_LO) && (idx_q <= IDX_ADDR_HI);
  assign word     = idx_q[0] ? {8'b0, s_axis_tdata} : {s_axis_tdata, 8'b0};
  // address and segment ranges overlap only for headers under 20 bytes,
  // which always fail status, so one adder serves both
  assign sum_n    = (in_seg || in_addr) ? ones_add(sum_q, word) : sum_q;
  assign idx_n    = (idx_q == IDX_MAX) ? idx_q : idx_q + 16'd1;

  always_comb begin
    snap_new.sum        = sum_n;
    snap_new.hdr_words  = hw_n;
    snap_new.version_ok = ver_n;
    snap_new.total_len  = tl_n;
    snap_new.proto      = proto_n;
    snap_new.count      = idx_n;
  end

  always_comb begin
    idx_d   = idx_q;
    sum_d   = sum_q;
    hw_d    = hw_q;
    tl_d    = tl_q;
    proto_d = proto_q;
    ver_d   = ver_q;
    if (in_beat) begin
      if (s_axis_tlast) begin
        idx_d   = 16'd0;
        sum_d   = 16'd0;
        hw_d    = 4'd0;
        tl_d    = 16'd0;
        proto_d = 8'd0;
        ver_d   = 1'b0;
      end else begin
        idx_d   = idx_n;
        sum_d   = sum_n;
        hw_d    = hw_n;
        tl_d    = tl_n;
        proto_d = proto_n;
        ver_d   = ver_n;
      end
    end
  end

  always_comb begin
    fin_valid_d = fin_valid_q;
    if (in_beat && s_axis_tlast) begin
      fin_valid_d = 1'b1;
    end else if (advance) begin
      fin_valid_d = 1'b0;
    end
    out_valid_d = advance ? fin_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 16'd0;
      sum_q       <= 16'd0;
      hw_q        <= 4'd0;
      tl_q        <= 16'd0;
      proto_q     <= 8'd0;
      ver_q       <= 1'b0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      hw_q        <= hw_d;
      tl_q        <= tl_d;
      proto_q     <= proto_d;
      ver_q       <= ver_d;
      fin_valid_q <= fin_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat && s_axis_tlast) begin
      snap_q <= snap_new;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  tucs_finish u_finish (
    .snap_i   (snap_q),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.offset, out_q.value};
  assign m_axis_tuser  = out_q.status;

endmodule

@@ hw/rtl/tucs_checker.sv @@
module tucs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import tucs_pkg::*;

  logic in_unused;
  assign in_unused = s_axis_tvalid & s_axis_tready & s_axis_tlast & (|s_axis_tdata);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // failed packets carry zero checksum and offset
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_VALID) |-> m_axis_tdata == 32'd0)
    else $error("failed status with nonzero payload");

  // good packets: offset is header (20..60) plus 6 or 16
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_VALID) |->
      m_axis_tdata[31:16] >= 16'd26 && m_axis_tdata[31:16] <= 16'd76)
    else $error("checksum offset out of range");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= ST_TRUNCATED)
    else $error("undefined status code");

endmodule

bind tcp_udp_checksum_stream_unit tucs_checker u_tucs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/sv/tcp_udp_checksum_stream_unit_tb.sv @@
module tcp_udp_checksum_stream_unit_tb;
  import tucs_pkg::*;

  // Tracks the packet in flight the way the block does and queues the
  // checksum result that each last byte must produce.
  class csum_board;
    logic [15:0] byte_cnt;
    logic [15:0] acc;
    logic [15:0] tot_len;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    bit          is_v4;
    result_t     pending_csums[$];
    int          errors;
    int          n_checked;
    int          per_status[8];

    function new();
      errors = 0;
      n_checked = 0;
      foreach (per_status[i]) per_status[i] = 0;
      restart();
    endfunction

    function void restart();
      byte_cnt = '0;
      acc      = '0;
      tot_len  = '0;
      ihl      = '0;
      proto    = '0;
      is_v4    = 1'b0;
    endfunction

    static function logic [15:0] ones_sum16(logic [15:0] a, logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + {15'b0, t[16]};
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int unsigned idx, hdr, pos, cnt;
      logic [15:0] word, s;
      bit known;
      result_t r;
      idx = byte_cnt;
      if (idx == IDX_VER_IHL) begin
        is_v4 = (b[7:4] == VERSION_IPV4);
        ihl   = b[3:0];
      end else if (idx == IDX_LEN_HI) begin
        tot_len[15:8] = b;
      end else if (idx == IDX_LEN_LO) begin
        tot_len[7:0] = b;
      end else if (idx == IDX_PROTO) begin
        proto = b;
      end
      hdr   = int'(ihl) * 4;
      pos   = (proto == TCP_PROTO) ? int'(TCP_CSUM_POS) :
              (proto == UDP_PROTO) ? int'(UDP_CSUM_POS) : 0;
      known = (pos != 0);
      word  = idx[0] ? {8'h00, b} : {b, 8'h00};
      if (idx >= IDX_ADDR_LO && idx <= IDX_ADDR_HI) acc = ones_sum16(acc, word);
      // segment bytes, checksum field skipped, padding past total length skipped
      if (idx >= hdr && idx < tot_len &&
          !(known && (idx == hdr + pos || idx == hdr + pos + 1)))
        acc = ones_sum16(acc, word);
      if (byte_cnt != IDX_MAX) byte_cnt = byte_cnt + 16'd1;
      cnt = byte_cnt;
      if (!last) return;

      r.value  = '0;
      r.offset = '0;
      if (!is_v4) begin
        r.status = ST_NOT_IPV4;
      end else if (ihl < MIN_HDR_WORDS) begin
        r.status = ST_HDR_SHORT;
      end else if (cnt < hdr) begin
        r.status = ST_TRUNCATED;
      end else if (!known) begin
        r.status = ST_OTHER_PROTO;
      end else if (int'(tot_len) < hdr + pos + 2) begin
        r.status = ST_SEG_SHORT;
      end else if (cnt < tot_len) begin
        r.status = ST_TRUNCATED;
      end else begin
        s = ones_sum16(acc, {8'h00, proto});
        s = ones_sum16(s, 16'(int'(tot_len) - hdr));
        r.value = ~s;
        if (proto == UDP_PROTO && r.value == 16'h0000) r.value = CSUM_ALL_ONES;
        r.offset = 16'(hdr + pos);
        r.status = ST_VALID;
      end
      pending_csums.push_back(r);
      restart();
    endfunction

    function void match_result(logic [31:0] data, logic [2:0] user);
      result_t e;
      if (pending_csums.size() == 0) begin
        $error("result beat with nothing pending: tdata %08h tuser %0d", data, user);
        errors++;
        return;
      end
      e = pending_csums.pop_front();
      if (data[15:0] !== e.value) begin
        $error("checksum_value: expected %04h, got %04h", e.value, data[15:0]);
        errors++;
      end
      if (data[31:16] !== e.offset) begin
        $error("checksum_offset: expected %0d, got %0d", e.offset, data[31:16]);
        errors++;
      end
      if (user !== 3'(e.status)) begin
        $error("status: expected %0d, got %0d", e.status, user);
        errors++;
      end
      n_checked++;
      per_status[int'(e.status)]++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  csum_board   board;
  logic [7:0]  pkt[$];
  bit          quiet = 1'b0;
  int          hold_req = 0;
  int          hold_left = 0;
  int          n_bytes = 0;
  int          n_pkts = 0;

  tcp_udp_checksum_stream_unit u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Builds an IPv4 packet into pkt. tlen_force < 0 means a consistent total
  // length; zero_udp rewrites the last segment word so the sum folds to 0xFFFF.
  task automatic build_packet(input logic [3:0] ver, input logic [3:0] hl,
                              input logic [7:0] prot, input int seg_len,
                              input int tlen_force, input int pad, input int cut,
                              input bit zero_udp);
    int hdr_n, tot, last_w;
    logic [15:0] s;
    pkt.delete();
    hdr_n = (hl < MIN_HDR_WORDS) ? 20 : int'(hl) * 4;
    tot = (tlen_force >= 0) ? tlen_force : hdr_n + seg_len;
    for (int i = 0; i < hdr_n + seg_len + pad; i++) pkt.push_back(8'($urandom_range(0, 255)));
    pkt[IDX_VER_IHL] = {ver, hl};
    pkt[IDX_LEN_HI]  = tot[15:8];
    pkt[IDX_LEN_LO]  = tot[7:0];
    pkt[IDX_PROTO]   = prot;
    if (zero_udp) begin
      last_w = hdr_n + seg_len - 2;
      pkt[hdr_n + UDP_CSUM_POS]     = 8'h00;
      pkt[hdr_n + UDP_CSUM_POS + 1] = 8'h00;
      pkt[last_w]     = 8'h00;
      pkt[last_w + 1] = 8'h00;
      s = '0;
      for (int i = IDX_ADDR_LO; i <= IDX_ADDR_HI; i += 2)
        s = csum_board::ones_sum16(s, {pkt[i], pkt[i + 1]});
      for (int i = hdr_n; i < hdr_n + seg_len; i += 2)
        s = csum_board::ones_sum16(s, {pkt[i], pkt[i + 1]});
      s = csum_board::ones_sum16(s, {8'h00, prot});
      s = csum_board::ones_sum16(s, 16'(seg_len));
      pkt[last_w]     = ~s[15:8];
      pkt[last_w + 1] = ~s[7:0];
    end
    repeat (cut) if (pkt.size() > 1) void'(pkt.pop_back());
  endtask

  task automatic send_pkt();
    for (int i = 0; i < pkt.size(); i++) begin
      while (!quiet && $urandom_range(0, 99) < 7) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= pkt[i];
      s_tlast  <= (i == pkt.size() - 1);
      @(posedge clk);
      while (s_axis_tready !== 1'b1) @(posedge clk);
      board.take_byte(pkt[i], i == pkt.size() - 1);
      n_bytes++;
    end
    n_pkts++;
  endtask

  // result side: check accepted beats, then pick next tready
  initial begin
    forever begin
      @(posedge clk);
      if (m_axis_tvalid === 1'b1 && m_tready) board.match_result(m_axis_tdata, m_axis_tuser);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  initial begin
    int rand_bytes, rand_pkts, roll, seg, hl, cut;
    logic [7:0] prot;
    logic [3:0] ver;
    board = new();
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    build_packet(VERSION_IPV4, MIN_HDR_WORDS, TCP_PROTO, 20, -1, 0, 0, 0); send_pkt();
    build_packet(VERSION_IPV4, MIN_HDR_WORDS, TCP_PROTO, 18, -1, 0, 0, 0); send_pkt();
    build_packet(VERSION_IPV4, MIN_HDR_WORDS, UDP_PROTO, 8, -1, 0, 0, 0); send_pkt();
    build_packet(VERSION_IPV4, MIN_HDR_WORDS, UDP_PROTO, 12, -1, 0, 0, 1); send_pkt();
    build_packet(VERSION_IPV4, 4'd15, TCP_PROTO, 24, -1, 0, 0, 0); send_pkt();
    build_packet(4'd6, MIN_HDR_WORDS, TCP_PROTO, 20, -1, 0, 0, 0); send_pkt();
    build_packet(VERSION_IPV4, 4'd4, TCP_PROTO, 20, -1, 0, 0, 0); send_pkt();
    build_packet(VERSION_IPV4, 4'd0, UDP_PROTO, 8, -1, 0, 0, 0); send_pkt();
    // cut off inside a 60-byte header
    build_packet(VERSION_IPV4, 4'd15, TCP_PROTO, 20, -1, 0, 70, 0); send_pkt();
    build_packet(VERSION_IPV4, MIN_HDR_WORDS, 8'd1, 20, -1, 0, 0, 0); send_pkt();
    build_packet(VERSION_IPV4, MIN_HDR_WORDS, TCP_PROTO, 17, -1, 0, 0, 0); send_pkt();
    build_packet(VERSION_IPV4, MIN_HDR_WORDS, UDP_PROTO, 7, -1, 0, 0, 0); send_pkt();
    build_packet(VERSION_IPV4, MIN_HDR_WORDS, TCP_PROTO, 30, -1, 0, 5, 0); send_pkt();
    build_packet(VERSION_IPV4, MIN_HDR_WORDS, UDP_PROTO, 10, -1, 4, 0, 0); send_pkt();
    // single-byte packets with all-zero and all-one data
    build_packet(4'h0, 4'h0, 8'h00, 0, -1, 0, 1000, 0); send_pkt();
    build_packet(4'hF, 4'hF, 8'hFF, 0, -1, 0, 1000, 0); send_pkt();
    // maximum total length claimed, packet ends far short of it
    build_packet(VERSION_IPV4, MIN_HDR_WORDS, UDP_PROTO, 30, 65535, 0, 0, 0); send_pkt();

    rand_bytes = 0;
    rand_pkts = 0;
    while (rand_bytes < 580 || rand_pkts < 12) begin
      quiet = (rand_pkts >= 3 && rand_pkts < 9);
      if (rand_pkts == 10) hold_req = 300;
      roll = $urandom_range(0, 99);
      hl   = ($urandom_range(0, 99) < 80) ? 5 : $urandom_range(6, 15);
      prot = $urandom_range(0, 1) ? TCP_PROTO : UDP_PROTO;
      seg  = (prot == TCP_PROTO) ? $urandom_range(18, 40) : $urandom_range(8, 30);
      if (roll < 65) begin
        build_packet(VERSION_IPV4, 4'(hl), prot, seg, -1,
                     ($urandom_range(0, 99) < 80) ? 0 : $urandom_range(1, 4), 0,
                     prot == UDP_PROTO && seg % 2 == 0 && seg >= 10 &&
                     $urandom_range(0, 9) == 0);
      end else if (roll < 75) begin
        cut = $urandom_range(1, hl * 4 + seg - 1);
        build_packet(VERSION_IPV4, 4'(hl), prot, seg, -1, 0, cut, 0);
      end else if (roll < 80) begin
        seg = (prot == TCP_PROTO) ? $urandom_range(0, 17) : $urandom_range(0, 7);
        build_packet(VERSION_IPV4, 4'(hl), prot, seg, -1, $urandom_range(0, 3), 0, 0);
      end else if (roll < 85) begin
        do ver = 4'($urandom_range(0, 15)); while (ver == VERSION_IPV4);
        build_packet(ver, 4'(hl), prot, seg, -1, 0, 0, 0);
      end else if (roll < 90) begin
        build_packet(VERSION_IPV4, 4'($urandom_range(0, 4)), prot, seg, -1, 0, 0, 0);
      end else if (roll < 95) begin
        do prot = 8'($urandom_range(0, 255)); while (prot == TCP_PROTO || prot == UDP_PROTO);
        build_packet(VERSION_IPV4, 4'(hl), prot, seg, -1, 0, 0, 0);
      end else begin
        // garbage with random header fields and total length
        build_packet(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     8'($urandom_range(0, 255)), $urandom_range(0, 10),
                     $urandom_range(0, 65535), 0, $urandom_range(0, 25), 0);
        for (int i = 0; i < pkt.size(); i++) pkt[i] = 8'($urandom_range(0, 255));
      end
      rand_bytes += pkt.size();
      send_pkt();
      rand_pkts++;
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    while (board.pending_csums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d packets (%0d bytes), %0d results checked, long output stall included.",
             n_pkts, n_bytes, board.n_checked);
    $display("Status mix: valid %0d, not-IPv4 %0d, other proto %0d,",
             board.per_status[ST_VALID], board.per_status[ST_NOT_IPV4],
             board.per_status[ST_OTHER_PROTO]);
    $display("  short seg %0d, short hdr %0d, truncated %0d",
             board.per_status[ST_SEG_SHORT], board.per_status[ST_HDR_SHORT],
             board.per_status[ST_TRUNCATED]);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tucs_pkg.sv
hw/rtl/tucs_finish.sv
hw/rtl/tcp_udp_checksum_stream_unit.sv
hw/rtl/tucs_checker.sv
tb/sv/tcp_udp_checksum_stream_unit_tb.sv
